// ----- rtl/core/sblp_pkg.sv -----
package sblp_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [13:0] world_x;
		logic [13:0] world_y;
	} cmd_t;

	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [15:0] byte_address;
		logic [7:0]  bit_mask;
		logic [3:0]  color;
		logic        line_done;
		logic        last;
	} pix_t;

	localparam logic [1:0] OP_MOVE = 2'd0;
	localparam logic [1:0] OP_DRAW = 2'd1;
	localparam logic [1:0] OP_DOT  = 2'd2;
	localparam logic [1:0] OP_CONT = 2'd3;

	localparam logic [2:0] REG_XDIV  = 3'd0;
	localparam logic [2:0] REG_YDIV  = 3'd1;
	localparam logic [2:0] REG_BOT   = 3'd2;
	localparam logic [2:0] REG_FLIP  = 3'd3;
	localparam logic [2:0] REG_COLOR = 3'd4;

	localparam int QW = 14;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_START,
		ST_RUN,
		ST_DOT
	} state_t;

	typedef struct packed {
		logic load_cmd;
		logic div_start;
		logic setup;
		logic start_line;
		logic pen_update;
		logic step;
		logic emit_dot;
		logic clr_busy;
		logic clr_count;
	} ctl_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       div_done;
		logic       busy;
		logic       done_px;
		logic       chunk_end;
		logic       out_full;
	} sts_t;

endpackage

// ----- rtl/core/sblp_divider.sv -----
module sblp_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [13:0] num_x,
	input  logic [13:0] num_y,
	input  logic [7:0]  den_x,
	input  logic [7:0]  den_y,
	output logic [13:0] quo_x,
	output logic [13:0] quo_y,
	output logic        done
);
	import sblp_pkg::*;

	logic [3:0]  cnt_q;
	logic        run_q;
	logic [13:0] nx_q, ny_q;
	logic [7:0]  dx_q, dy_q;
	logic [8:0]  rx_q, ry_q;
	logic [8:0]  tx, ty;
	logic [8:0]  sx, sy;

	assign tx = {rx_q[7:0], nx_q[QW-1]};
	assign ty = {ry_q[7:0], ny_q[QW-1]};
	assign sx = tx - {1'b0, dx_q};
	assign sy = ty - {1'b0, dy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(QW - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nx_q <= num_x;
			ny_q <= num_y;
			dx_q <= (den_x == 8'd0) ? 8'd1 : den_x;
			dy_q <= (den_y == 8'd0) ? 8'd1 : den_y;
			rx_q <= '0;
			ry_q <= '0;
		end else if (run_q) begin
			if (!sx[8]) begin
				rx_q <= sx;
				nx_q <= {nx_q[QW-2:0], 1'b1};
			end else begin
				rx_q <= tx;
				nx_q <= {nx_q[QW-2:0], 1'b0};
			end
			if (!sy[8]) begin
				ry_q <= sy;
				ny_q <= {ny_q[QW-2:0], 1'b1};
			end else begin
				ry_q <= ty;
				ny_q <= {ny_q[QW-2:0], 1'b0};
			end
		end
	end

	assign quo_x = nx_q;
	assign quo_y = ny_q;

endmodule

// ----- rtl/core/sblp_datapath.sv -----
module sblp_datapath #(
	parameter int MAX_COLUMN    = 639,
	parameter int BYTES_PER_ROW = 80,
	parameter int CHUNK         = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sblp_pkg::ctl_t ctl,
	output sblp_pkg::sts_t sts,
	input  sblp_pkg::cmd_t cmd,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [8:0]     cfg_data,
	output sblp_pkg::pix_t pix,
	output logic           pix_valid,
	input  logic           pix_stall
);
	import sblp_pkg::*;

	localparam int CW = 12;
	localparam int NW = $clog2(CHUNK + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_COLUMN);

	logic [7:0]  xdiv_q, ydiv_q;
	logic [8:0]  bot_q;
	logic        flip_q;
	logic [3:0]  color_q;

	logic [1:0]  op_q;
	logic [13:0] wx_q, wy_q;
	logic [13:0] qx, qy;
	logic        div_done;

	logic [CW-1:0] px_q, py_q;
	logic [CW-1:0] nx_q, ny_q;
	logic [CW-1:0] wkx_q, wky_q, wend_q;
	logic signed [CW+1:0] err_q, smin_q, sboth_q;
	logic        down_q, ymaj_q, busy_q;
	logic [NW-1:0] cnt_q;

	logic [CW-1:0] dxa, dya;
	logic        ym;

	logic [CW-1:0] maj_pos;
	logic        done_now;

	pix_t        pix_q;
	logic        pv_q;
	logic [15:0] rowmul;
	logic [CW-1:0] ox, oy;
	logic        odone, olast;

	sblp_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.div_start),
		.num_x (wx_q),
		.num_y (wy_q),
		.den_x (xdiv_q),
		.den_y (ydiv_q),
		.quo_x (qx),
		.quo_y (qy),
		.done  (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xdiv_q <= 8'd35;
			ydiv_q <= 8'd35;
			bot_q <= 9'd479;
			flip_q <= 1'b0;
			color_q <= 4'd15;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_XDIV: xdiv_q <= cfg_data[7:0];
				REG_YDIV: ydiv_q <= cfg_data[7:0];
				REG_BOT: bot_q <= cfg_data;
				REG_FLIP: flip_q <= cfg_data[0];
				REG_COLOR: color_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_MOVE;
		end else if (ctl.load_cmd) begin
			op_q <= cmd.opcode;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			wx_q <= cmd.world_x;
			wy_q <= cmd.world_y;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			if ({2'b0, qx} > 16'(MAX_COLUMN))
				nx_q <= MAXC;
			else
				nx_q <= qx[CW-1:0];
			if (!flip_q) begin
				if ({5'b0, qy} > {10'b0, bot_q})
					ny_q <= '0;
				else
					ny_q <= CW'(bot_q) - qy[CW-1:0];
			end else begin
				if ({5'b0, qy} > {10'b0, bot_q})
					ny_q <= CW'(bot_q);
				else
					ny_q <= qy[CW-1:0];
			end
		end
	end

	assign dxa = (nx_q > px_q) ? nx_q - px_q : px_q - nx_q;
	assign dya = (ny_q > py_q) ? ny_q - py_q : py_q - ny_q;
	assign ym = dya > dxa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			wkx_q <= '0;
			wky_q <= '0;
			wend_q <= '0;
			err_q <= '0;
			smin_q <= '0;
			sboth_q <= '0;
			down_q <= 1'b0;
			ymaj_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (ctl.clr_busy)
				busy_q <= 1'b0;
			if (ctl.start_line) begin
				ymaj_q <= ym;
				busy_q <= 1'b1;
				if (!ym) begin
					if (nx_q < px_q) begin
						wkx_q <= nx_q; wky_q <= ny_q; wend_q <= px_q;
						down_q <= py_q < ny_q;
					end else begin
						wkx_q <= px_q; wky_q <= py_q; wend_q <= nx_q;
						down_q <= ny_q < py_q;
					end
					err_q <= (CW+2)'(2 * $signed({2'b0, dya}) - $signed({2'b0, dxa}));
					smin_q <= (CW+2)'(2 * $signed({2'b0, dya}));
					sboth_q <= (CW+2)'(2 * ($signed({2'b0, dya}) - $signed({2'b0, dxa})));
				end else begin
					if (ny_q < py_q) begin
						wkx_q <= nx_q; wky_q <= ny_q; wend_q <= py_q;
						down_q <= px_q < nx_q;
					end else begin
						wkx_q <= px_q; wky_q <= py_q; wend_q <= ny_q;
						down_q <= nx_q < px_q;
					end
					err_q <= (CW+2)'(2 * $signed({2'b0, dxa}) - $signed({2'b0, dya}));
					smin_q <= (CW+2)'(2 * $signed({2'b0, dxa}));
					sboth_q <= (CW+2)'(2 * ($signed({2'b0, dxa}) - $signed({2'b0, dya})));
				end
			end
			if (ctl.pen_update) begin
				px_q <= nx_q;
				py_q <= ny_q;
			end
			if (ctl.step) begin
				if (done_now) begin
					busy_q <= 1'b0;
				end else begin
					if (ymaj_q)
						wky_q <= wky_q + 1'b1;
					else
						wkx_q <= wkx_q + 1'b1;
					if (err_q < 0) begin
						err_q <= err_q + smin_q;
					end else begin
						err_q <= err_q + sboth_q;
						if (ymaj_q)
							wkx_q <= down_q ? wkx_q - 1'b1 : wkx_q + 1'b1;
						else
							wky_q <= down_q ? wky_q - 1'b1 : wky_q + 1'b1;
					end
				end
			end
		end
	end

	assign maj_pos = ymaj_q ? wky_q : wkx_q;
	assign done_now = maj_pos >= wend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (ctl.clr_count)
			cnt_q <= '0;
		else if (ctl.step)
			cnt_q <= cnt_q + 1'b1;
	end

	assign ox = ctl.emit_dot ? nx_q : wkx_q;
	assign oy = ctl.emit_dot ? ny_q : wky_q;
	assign odone = ctl.emit_dot ? 1'b1 : done_now;
	assign olast = ctl.emit_dot ? 1'b1 : (done_now || (cnt_q == NW'(CHUNK - 1)));
	assign rowmul = 16'(oy[8:0]) * 16'(BYTES_PER_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (ctl.step || ctl.emit_dot) begin
			pv_q <= 1'b1;
		end else if (!pix_stall) begin
			pv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step || ctl.emit_dot) begin
			pix_q.pixel_x <= ox[9:0];
			pix_q.pixel_y <= oy[8:0];
			pix_q.byte_address <= rowmul + 16'(ox[9:3]);
			pix_q.bit_mask <= 8'h80 >> ox[2:0];
			pix_q.color <= color_q;
			pix_q.line_done <= odone;
			pix_q.last <= olast;
		end
	end

	assign pix = pix_q;
	assign pix_valid = pv_q;

	assign sts.opcode = op_q;
	assign sts.div_done = div_done;
	assign sts.busy = busy_q;
	assign sts.done_px = done_now;
	assign sts.chunk_end = cnt_q == NW'(CHUNK - 1);
	assign sts.out_full = pv_q && pix_stall;

endmodule

// ----- rtl/core/sblp_control.sv -----
module sblp_control (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  sblp_pkg::sts_t sts,
	output sblp_pkg::ctl_t ctl
);
	import sblp_pkg::*;

	state_t state_q, state_d;
	logic   acc;

	assign acc = cmd_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.opcode == OP_CONT)
					state_d = sts.busy ? ST_RUN : ST_IDLE;
				else if (sts.div_done)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				case (sts.opcode)
					OP_DRAW: state_d = ST_START;
					OP_DOT: state_d = ST_DOT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_START: state_d = ST_RUN;
			ST_DOT: begin
				if (!sts.out_full)
					state_d = ST_IDLE;
			end
			ST_RUN: begin
				if (!sts.out_full && (sts.done_px || sts.chunk_end))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		cmd_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				ctl.load_cmd = cmd_valid;
				ctl.clr_count = 1'b1;
			end
			ST_DIV: begin
				ctl.setup = sts.div_done;
			end
			ST_SETUP: begin
				ctl.clr_busy = 1'b1;
				ctl.pen_update = sts.opcode != OP_DRAW;
			end
			ST_START: begin
				ctl.start_line = 1'b1;
				ctl.pen_update = 1'b1;
			end
			ST_DOT: ctl.emit_dot = !sts.out_full;
			ST_RUN: ctl.step = !sts.out_full;
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/sblp_starter.sv -----
module sblp_starter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic [1:0]     opcode,
	input  sblp_pkg::ctl_t ctl_in,
	output sblp_pkg::ctl_t ctl_out
);
	import sblp_pkg::*;

	logic kick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kick_q <= 1'b0;
		else
			kick_q <= load && (opcode != OP_CONT);
	end

	always_comb begin
		ctl_out = ctl_in;
		ctl_out.div_start = kick_q;
	end

endmodule

// ----- rtl/core/scaled_bresenham_line_plotter_unit.sv -----
// One command is taken at a time. Move, draw and dot first load the command, start
// a restoring divider that divides both world coordinates side by side, then clamp
// and set up the line; a draw then registers its pixels at one per cycle while the
// pixel output is not stalled, up to CHUNK per command. A continue skips the
// divider. A single output register sits on the pixel side.
module scaled_bresenham_line_plotter_unit #(
	parameter int MAX_COLUMN    = 639,
	parameter int BYTES_PER_ROW = 80,
	parameter int CHUNK         = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  sblp_pkg::cmd_t cmd,
	output logic           pix_valid,
	input  logic           pix_stall,
	output sblp_pkg::pix_t pix,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [8:0]     cfg_data
);
	import sblp_pkg::*;

	ctl_t ctl_c, ctl;
	sts_t sts;

	sblp_control u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.sts      (sts),
		.ctl      (ctl_c)
	);

	sblp_starter u_st (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl_c.load_cmd),
		.opcode (cmd.opcode),
		.ctl_in (ctl_c),
		.ctl_out(ctl)
	);

	sblp_datapath #(
		.MAX_COLUMN   (MAX_COLUMN),
		.BYTES_PER_ROW(BYTES_PER_ROW),
		.CHUNK        (CHUNK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix      (pix),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall)
	);

endmodule

// ----- rtl/core/sblp_checker.sv -----
module sblp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           pix_valid,
	input logic           pix_stall,
	input sblp_pkg::pix_t pix
);
	import sblp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("stalled pixel beat changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.line_done |-> pix.last)
		else $error("line end without last");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> $onehot(pix.bit_mask))
		else $error("bit mask not one-hot");

	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.last |-> cmd_stall)
		else $error("command taken mid chunk");

endmodule

bind scaled_bresenham_line_plotter_unit sblp_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.pix_valid(pix_valid),
	.pix_stall(pix_stall),
	.pix      (pix)
);

// ----- dv/sblp_plot_checker.sv -----
`timescale 1ns / 100ps

module sblp_plot_checker
	import sblp_pkg::*;
#(
	parameter int MAX_COLUMN    = 639,
	parameter int BYTES_PER_ROW = 80,
	parameter int CHUNK         = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_stall,
	input  cmd_t       cmd,
	input  logic       pix_valid,
	input  logic       pix_stall,
	input  pix_t       pix,
	input  logic       cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [8:0] cfg_data,
	output int         fails,
	output int         owed
);

	int   x_div, y_div, bot_row;
	bit   flip_off;
	logic [3:0] ink;
	int   pen_x, pen_y, walk_x, walk_y, walk_end, err_term, step_minor, step_both;
	bit   minor_down, y_major, line_busy;
	pix_t plot_q[$];

	task automatic report(string field, int got, int want);
		$display("%0t: pixel %s is %0d, expected %0d", $realtime, field, got, want);
		fails++;
	endtask

	function automatic void scale_point(input logic [13:0] wx, input logic [13:0] wy,
			output int x, output int y);
		int xd, yd;
		xd = (x_div == 0) ? 1 : x_div;
		yd = (y_div == 0) ? 1 : y_div;
		x = int'(wx) / xd;
		y = int'(wy) / yd;
		if (!flip_off)
			y = bot_row - y;
		if (x > MAX_COLUMN) x = MAX_COLUMN;
		if (y > bot_row) y = bot_row;
		if (y < 0) y = 0;
	endfunction

	function automatic void queue_pixel(input int x, input int y, input bit done);
		pix_t p;
		p.pixel_x      = 10'(x);
		p.pixel_y      = 9'(y);
		p.byte_address = 16'(y * BYTES_PER_ROW + x / 8);
		p.bit_mask     = 8'h80 >> x[2:0];
		p.color        = ink;
		p.line_done    = done;
		p.last         = 1'b0;
		plot_q.push_back(p);
	endfunction

	function automatic void begin_line(input int x1, input int y1, input int x2, input int y2);
		int dx, dy, major, minor;
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		y_major = dy > dx;
		if (!y_major) begin
			if (x2 < x1) begin
				walk_x = x2; walk_y = y2; walk_end = x1; minor_down = y1 < y2;
			end else begin
				walk_x = x1; walk_y = y1; walk_end = x2; minor_down = y2 < y1;
			end
			major = dx; minor = dy;
		end else begin
			if (y2 < y1) begin
				walk_x = x2; walk_y = y2; walk_end = y1; minor_down = x1 < x2;
			end else begin
				walk_x = x1; walk_y = y1; walk_end = y2; minor_down = x2 < x1;
			end
			major = dy; minor = dx;
		end
		err_term   = 2 * minor - major;
		step_minor = 2 * minor;
		step_both  = 2 * (minor - major);
		line_busy  = 1'b1;
	endfunction

	function automatic void walk_chunk();
		int n;
		bit done;
		n = 0;
		while (line_busy && n < CHUNK) begin
			done = (y_major ? walk_y : walk_x) >= walk_end;
			queue_pixel(walk_x, walk_y, done);
			n++;
			if (done) begin
				line_busy = 1'b0;
			end else begin
				if (y_major) walk_y++; else walk_x++;
				if (err_term < 0) begin
					err_term += step_minor;
				end else begin
					if (y_major) walk_x += minor_down ? -1 : 1;
					else walk_y += minor_down ? -1 : 1;
					err_term += step_both;
				end
			end
		end
		if (n > 0)
			plot_q[plot_q.size() - 1].last = 1'b1;
	endfunction

	function automatic void take_command(input cmd_t c);
		int x, y;
		if (c.opcode == OP_CONT) begin
			walk_chunk();
			return;
		end
		line_busy = 1'b0;
		scale_point(c.world_x, c.world_y, x, y);
		case (c.opcode)
			OP_DOT: begin
				queue_pixel(x, y, 1'b1);
				plot_q[plot_q.size() - 1].last = 1'b1;
			end
			OP_DRAW: begin
				begin_line(pen_x, pen_y, x, y);
				walk_chunk();
			end
			default: ;
		endcase
		pen_x = x;
		pen_y = y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_t want;
		if (!arst_n) begin
			x_div = 35; y_div = 35; bot_row = 479; flip_off = 0; ink = 4'd15;
			pen_x = 0; pen_y = 0; walk_x = 0; walk_y = 0; walk_end = 0;
			err_term = 0; step_minor = 0; step_both = 0;
			minor_down = 0; y_major = 0; line_busy = 0;
			plot_q.delete();
			fails = 0;
			owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_XDIV:  x_div = int'(cfg_data[7:0]);
					REG_YDIV:  y_div = int'(cfg_data[7:0]);
					REG_BOT:   bot_row = int'(cfg_data);
					REG_FLIP:  flip_off = cfg_data[0];
					REG_COLOR: ink = cfg_data[3:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall) begin
				if (plot_q.size() == 0) begin
					$display("%0t: pixel beat with nothing expected", $realtime);
					fails++;
				end else begin
					want = plot_q.pop_front();
					if (pix.pixel_x != want.pixel_x)
						report("x", pix.pixel_x, want.pixel_x);
					if (pix.pixel_y != want.pixel_y)
						report("y", pix.pixel_y, want.pixel_y);
					if (pix.byte_address != want.byte_address)
						report("address", pix.byte_address, want.byte_address);
					if (pix.bit_mask != want.bit_mask)
						report("mask", pix.bit_mask, want.bit_mask);
					if (pix.color != want.color)
						report("color", pix.color, want.color);
					if (pix.line_done != want.line_done)
						report("line_done", pix.line_done, want.line_done);
					if (pix.last != want.last)
						report("last", pix.last, want.last);
				end
			end
			if (cmd_valid && !cmd_stall)
				take_command(cmd);
			owed = plot_q.size();
		end
	end

endmodule

// ----- dv/scaled_bresenham_line_plotter_unit_tb.sv -----
`timescale 1ns / 100ps

module scaled_bresenham_line_plotter_unit_tb;
	import sblp_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_t       cmd = '0;
	logic       pix_valid;
	logic       pix_stall = 1'b0;
	pix_t       pix;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_idx = REG_XDIV;
	logic [8:0] cfg_data = '0;
	int         fails, owed;
	bit         calm = 1'b0;

	always #2 clk = ~clk;

	scaled_bresenham_line_plotter_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	sblp_plot_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fails(fails), .owed(owed)
	);

	always @(posedge clk) begin
		pix_stall <= !calm && ($urandom_range(99) < 27);
	end

	task automatic send(input logic [1:0] op, input logic [13:0] wx, input logic [13:0] wy);
		while (!calm && $urandom_range(99) < 27) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid     <= 1'b1;
		cmd.opcode    <= op;
		cmd.world_x   <= wx;
		cmd.world_y   <= wy;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic setup(input int xd, input int yd, input int bot, input int flip,
			input int ink);
		int vals[5];
		vals = '{xd, yd, bot, flip, ink};
		for (int i = 0; i < 5; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= 3'(i);
			cfg_data <= 9'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [13:0] coord();
		case ($urandom_range(3))
			0: return 14'($urandom);
			1: return 14'($urandom_range(0, 600));
			2: return 14'($urandom_range(16000, 16383));
			default: return 14'($urandom_range(0, 8191));
		endcase
	endfunction

	task automatic random_batch(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 12) begin
				send(OP_MOVE, coord(), coord());
			end else if (r < 24) begin
				send(OP_DOT, coord(), coord());
			end else if (r < 32) begin
				send(OP_CONT, 14'($urandom), 14'($urandom));
			end else begin
				send(OP_DRAW, coord(), coord());
				repeat ($urandom_range(0, 10)) begin
					send(OP_CONT, 14'($urandom), 14'($urandom));
					i++;
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		setup(35, 35, 479, 0, 15);
		send(OP_CONT, 14'd0, 14'd0);
		send(OP_MOVE, 14'd0, 14'd0);
		send(OP_DRAW, 14'h3FFF, 14'h3FFF);
		repeat (2) send(OP_CONT, 14'h3FFF, 14'h0);
		send(OP_DOT, 14'h3FFF, 14'h0);
		send(OP_DOT, 14'h0, 14'h3FFF);
		send(OP_DRAW, 14'd700, 14'h3FFF);
		send(OP_MOVE, 14'h2AAA, 14'h1555);
		send(OP_DRAW, 14'h1555, 14'h2AAA);
		send(OP_CONT, 14'h0, 14'h0);
		send(OP_DRAW, 14'd0, 14'd16000);
		send(OP_DRAW, 14'd16000, 14'd70);
		send(OP_DRAW, 14'd35, 14'd35);
		repeat (6) send(OP_CONT, 14'h0, 14'h0);
		drain();
		setup(1, 1, 479, 1, 0);
		send(OP_MOVE, 14'd0, 14'd479);
		send(OP_DRAW, 14'd600, 14'd0);
		send(OP_DRAW, 14'd700, 14'd600);
		send(OP_DOT, 14'd639, 14'd479);
		random_batch(35);
		drain();
		setup(255, 255, 0, 0, 5);
		calm = 1'b1;
		random_batch(35);
		drain();
		calm = 1'b0;
		setup(0, 0, 511, 1, 10);
		random_batch(35);
		drain();
		setup(17, 40, 300, 0, $urandom_range(15));
		random_batch(40);
		drain();
		setup(3, 5, 479, 0, 7);
		random_batch(40);
		drain();
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- scaled_bresenham_line_plotter_unit.f -----
rtl/core/sblp_pkg.sv
rtl/core/sblp_divider.sv
rtl/core/sblp_datapath.sv
rtl/core/sblp_control.sv
rtl/core/sblp_starter.sv
rtl/core/scaled_bresenham_line_plotter_unit.sv
rtl/core/sblp_checker.sv
dv/sblp_plot_checker.sv
dv/scaled_bresenham_line_plotter_unit_tb.sv
